// ----- design/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and codes for the set-associative LRU cache tag store.
// ----------------------------------------------------------------------------
package slc_pkg;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int ADDR_W = 64;
	localparam int TAG_W = 64;
	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// register index (word address)
	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS = 2'd2;

	// operation codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	typedef enum logic [1:0] {
		OUT_HIT = 2'd0,
		OUT_FILL = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [5:0] block_bits;
		logic [3:0] ways;
	} cfg_t;

endpackage

// ----- design/set_assoc_lru_cache_model.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative tag store with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
// A load or store reads the set row from the tag RAM, then does the compare,
// victim pick and write-back; a modify does all of this twice, since its second access
// re-reads the row just written. busy covers all of it. Each result appears
// with done for one cycle, one cycle after its write-back, and must be taken
// then: the receiver cannot stall. After reset the block holds busy while it
// clears the tag RAM one row per cycle; the APB port works throughout. Write
// configuration only while busy is low.
module set_assoc_lru_cache_model import slc_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS = 8,
	parameter int STAMP_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [ADDR_W-1:0]  address,
	output logic               done,
	output logic [1:0]         outcome,
	output logic               last,
	output logic [COUNT_W-1:0] hits_total,
	output logic [COUNT_W-1:0] misses_total,
	output logic [COUNT_W-1:0] evictions_total,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SI_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int ROW_W = MAX_WAYS * (1 + TAG_W + STAMP_WIDTH);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic [ROW_W-1:0]       mem [SETS];
	logic [ROW_W-1:0]       rd_row_q;
	logic [ROW_W-1:0]       wr_row;
	logic                   rd_en;
	logic                   wr_en;
	logic [SI_W-1:0]        rd_idx;
	logic [SI_W-1:0]        wr_idx;
	logic [SI_W-1:0]        clr_idx_q;
	logic [SI_W-1:0]        set_q;
	logic [SI_W-1:0]        set_in;
	logic [SI_W-1:0]        set_mask;
	logic [2:0]             s_eff;
	logic [ADDR_W-1:0]      addr_shift;
	logic [ADDR_W-1:0]      addr_q;
	logic                   modify_q;
	logic                   accept;

	logic [STAMP_WIDTH-1:0] use_clock_q;
	logic [STAMP_WIDTH-1:0] stamp_next;
	logic [COUNT_W-1:0]     hits_q;
	logic [COUNT_W-1:0]     misses_q;
	logic [COUNT_W-1:0]     evicts_q;
	logic                   done_q;
	logic [1:0]             outcome_q;
	logic                   last_q;

	logic [MAX_WAYS-1:0]                  rd_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] rd_stamp;
	logic [MAX_WAYS-1:0]                  nw_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]       nw_tag;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] nw_stamp;
	outcome_t                             lk_outcome;

	slc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slc_lookup #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.STAMP_WIDTH  (STAMP_WIDTH)
	) u_lookup (
		.cfg       (cfg),
		.address   (addr_q),
		.stamp_new (stamp_next),
		.valid_in  (rd_valid),
		.tag_in    (rd_tag),
		.stamp_in  (rd_stamp),
		.outcome   (lk_outcome),
		.valid_out (nw_valid),
		.tag_out   (nw_tag),
		.stamp_out (nw_stamp)
	);

	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	// set index of the incoming word
	assign s_eff = (32'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
	assign set_mask = ~({SI_W{1'b1}} << s_eff);
	assign addr_shift = address >> cfg.block_bits;
	assign set_in = addr_shift[SI_W-1:0] & set_mask;

	assign rd_en = accept | (state_q == ST_READ);
	assign rd_idx = (state_q == ST_READ) ? set_q : set_in;
	assign wr_en = (state_q == ST_CLEAR) | (state_q == ST_LOOK);
	assign wr_idx = (state_q == ST_CLEAR) ? clr_idx_q : set_q;
	assign wr_row = (state_q == ST_CLEAR) ? '0 : {nw_valid, nw_tag, nw_stamp};
	assign {rd_valid, rd_tag, rd_stamp} = rd_row_q;
	assign stamp_next = use_clock_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_row;
		if (rd_en)
			rd_row_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			modify_q <= 1'b0;
			use_clock_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			evicts_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_LOOK);
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == SI_W'(SETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						modify_q <= (operation == OP_MODIFY);
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					use_clock_q <= stamp_next;
					if (lk_outcome == OUT_HIT) begin
						if (hits_q != COUNT_MAX)
							hits_q <= hits_q + 1'b1;
					end else begin
						if (misses_q != COUNT_MAX)
							misses_q <= misses_q + 1'b1;
					end
					if (lk_outcome == OUT_EVICT && evicts_q != COUNT_MAX)
						evicts_q <= evicts_q + 1'b1;
					modify_q <= 1'b0;
					state_q <= modify_q ? ST_READ : ST_IDLE;
				end
				ST_READ: state_q <= ST_LOOK;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// access payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= address;
			set_q <= set_in;
		end
		if (state_q == ST_LOOK) begin
			outcome_q <= lk_outcome;
			last_q <= ~modify_q;
		end
	end

	assign done = done_q;
	assign outcome = outcome_q;
	assign last = last_q;
	assign hits_total = hits_q;
	assign misses_total = misses_q;
	assign evictions_total = evicts_q;

endmodule

// ----- design/slc_cfg.sv -----
// ----------------------------------------------------------------------------
// slc_cfg
// APB register file: set_bits, block_bits and ways, with readback.
// ----------------------------------------------------------------------------
module slc_cfg import slc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd0;
			block_bits_q <= 6'd0;
			ways_q <= 4'd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SET_BITS: set_bits_q <= pwdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= pwdata[5:0];
				REG_WAYS: ways_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SET_BITS: prdata = {29'd0, set_bits_q};
			REG_BLOCK_BITS: prdata = {26'd0, block_bits_q};
			REG_WAYS: prdata = {28'd0, ways_q};
			default: prdata = '0;
		endcase
	end

	assign cfg = '{set_bits: set_bits_q, block_bits: block_bits_q, ways: ways_q};

endmodule

// ----- design/slc_lookup.sv -----
// ----------------------------------------------------------------------------
// slc_lookup
// Tag compare over one set, free-way search and LRU victim tree; builds the
// updated set row to write back.
// ----------------------------------------------------------------------------
module slc_lookup import slc_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS = 8,
	parameter int STAMP_WIDTH = 32
) (
	input  cfg_t                                     cfg,
	input  logic [ADDR_W-1:0]                        address,
	input  logic [STAMP_WIDTH-1:0]                   stamp_new,
	input  logic [MAX_WAYS-1:0]                      valid_in,
	input  logic [MAX_WAYS-1:0][TAG_W-1:0]           tag_in,
	input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]     stamp_in,
	output outcome_t                                 outcome,
	output logic [MAX_WAYS-1:0]                      valid_out,
	output logic [MAX_WAYS-1:0][TAG_W-1:0]           tag_out,
	output logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]     stamp_out
);

	localparam int WC_W = $clog2(MAX_WAYS + 1);
	localparam int WI_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LEAVES = 1 << $clog2(MAX_WAYS);
	localparam int NODES = 2 * LEAVES - 1;

	logic [2:0]             s_eff;
	logic [6:0]             split;
	logic [TAG_W-1:0]       tag;
	logic [WC_W-1:0]        w_eff;
	logic [MAX_WAYS-1:0]    used;
	logic [MAX_WAYS-1:0]    hit_vec;
	logic [MAX_WAYS-1:0]    free_vec;
	logic [WI_W-1:0]        hit_way;
	logic [WI_W-1:0]        free_way;
	logic [WI_W-1:0]        way;
	logic                   nd_en    [NODES];
	logic [STAMP_WIDTH-1:0] nd_stamp [NODES];
	logic [WI_W-1:0]        nd_idx   [NODES];

	assign s_eff = (32'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
	assign split = 7'(cfg.block_bits) + 7'(s_eff);
	// shift of 64 or more yields a zero tag
	assign tag = address >> split;

	always_comb begin
		if (cfg.ways == 4'd0)
			w_eff = WC_W'(1);
		else if (32'(cfg.ways) > MAX_WAYS)
			w_eff = WC_W'(MAX_WAYS);
		else
			w_eff = WC_W'(cfg.ways);
	end

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			used[i] = WC_W'(i) < w_eff;
			hit_vec[i] = used[i] & valid_in[i] & (tag_in[i] == tag);
			free_vec[i] = used[i] & ~valid_in[i];
		end
		hit_way = '0;
		free_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i])
				hit_way = WI_W'(i);
			if (free_vec[i])
				free_way = WI_W'(i);
		end
	end

	// min-stamp tournament, lower way wins ties
	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			nd_en[LEAVES - 1 + i] = (i < MAX_WAYS) ? used[i] : 1'b0;
			nd_stamp[LEAVES - 1 + i] = (i < MAX_WAYS) ? stamp_in[i] : '0;
			nd_idx[LEAVES - 1 + i] = WI_W'(i);
		end
		for (int n = LEAVES - 2; n >= 0; n--) begin
			if (!nd_en[2*n+1] ||
			    (nd_en[2*n+2] && (nd_stamp[2*n+2] < nd_stamp[2*n+1]))) begin
				nd_en[n] = nd_en[2*n+2];
				nd_stamp[n] = nd_stamp[2*n+2];
				nd_idx[n] = nd_idx[2*n+2];
			end else begin
				nd_en[n] = nd_en[2*n+1];
				nd_stamp[n] = nd_stamp[2*n+1];
				nd_idx[n] = nd_idx[2*n+1];
			end
		end
	end

	always_comb begin
		if (|hit_vec) begin
			outcome = OUT_HIT;
			way = hit_way;
		end else if (|free_vec) begin
			outcome = OUT_FILL;
			way = free_way;
		end else begin
			outcome = OUT_EVICT;
			way = nd_idx[0];
		end
		valid_out = valid_in;
		tag_out = tag_in;
		stamp_out = stamp_in;
		valid_out[way] = 1'b1;
		tag_out[way] = tag;
		stamp_out[way] = stamp_new;
	end

endmodule

// ----- design/slc_checker.sv -----
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks on the cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker import slc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         outcome,
	input logic               last,
	input logic [COUNT_W-1:0] hits_total,
	input logic [COUNT_W-1:0] misses_total,
	input logic [COUNT_W-1:0] evictions_total
);

	// an accepted word keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// first result of a modify is followed by its last result, a hit, with done low in between
	a_modify_second_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> !done ##1 (done && last && outcome == OUT_HIT))
		else $error("modify second result missing or not a hit");

	// totals move only with a result
	a_totals_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(hits_total) && $stable(misses_total) &&
		$stable(evictions_total))
		else $error("totals changed without a result");

	// a hit counts once, unless saturated
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_HIT && $past(hits_total) != COUNT_MAX |->
		hits_total == $past(hits_total) + 1'b1)
		else $error("hit total not incremented");

	// an eviction also counts as a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_EVICT && $past(misses_total) != COUNT_MAX |->
		misses_total == $past(misses_total) + 1'b1)
		else $error("evicting miss not counted as miss");

endmodule

bind set_assoc_lru_cache_model slc_checker u_slc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.outcome         (outcome),
	.last            (last),
	.hits_total      (hits_total),
	.misses_total    (misses_total),
	.evictions_total (evictions_total)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag store. Accesses
// go in through start/busy; each result word is checked against a mirror of
// the tag store that tracks valid bits, tags, use stamps and the saturating
// totals. Geometry is changed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import slc_pkg::*;

	localparam int SET_BITS_CAP = 6;
	localparam int WAYS_CAP = 8;
	localparam int LINE_COUNT = (1 << SET_BITS_CAP) * WAYS_CAP;
	localparam int CYCLE_LIMIT = 200_000;
	// operation code 3 has no name in the package; the block takes it as a load
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		outcome_t   outcome;
		bit         last;
		bit [31:0]  hits;
		bit [31:0]  misses;
		bit [31:0]  evicts;
	} access_result_t;

	class lru_tag_tracker;
		bit [2:0]  set_bits;
		bit [5:0]  block_bits;
		bit [3:0]  ways;
		bit        line_valid [LINE_COUNT];
		bit [63:0] line_tag [LINE_COUNT];
		bit [31:0] line_stamp [LINE_COUNT];
		bit [31:0] use_clock;
		bit [31:0] hit_count;
		bit [31:0] miss_count;
		bit [31:0] evict_count;
		access_result_t pending_results[$];
		int mismatches;

		function new();
			ways = 4'd1;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_SET_BITS: set_bits = value[2:0];
				REG_BLOCK_BITS: block_bits = value[5:0];
				REG_WAYS: ways = value[3:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_set_bits();
			return (set_bits > SET_BITS_CAP) ? SET_BITS_CAP : set_bits;
		endfunction

		function int unsigned eff_ways();
			if (ways == 0)
				return 1;
			return (ways > WAYS_CAP) ? WAYS_CAP : ways;
		endfunction

		function bit [31:0] sat_inc(bit [31:0] v);
			return (v == COUNT_MAX) ? v : v + 32'd1;
		endfunction

		function outcome_t access_line(logic [63:0] addr);
			int unsigned s, b, w, sb, base, victim, i;
			bit [63:0] tag;
			bit [63:0] set_idx;
			s = eff_set_bits();
			b = 32'(block_bits);
			w = eff_ways();
			sb = s + b;
			set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
			tag = (sb >= 64) ? 64'd0 : (addr >> sb);
			base = 32'(set_idx) * WAYS_CAP;
			for (i = 0; i < w; i++) begin
				if (line_valid[base+i] && line_tag[base+i] == tag) begin
					use_clock = use_clock + 32'd1;
					line_stamp[base+i] = use_clock;
					hit_count = sat_inc(hit_count);
					return OUT_HIT;
				end
			end
			for (i = 0; i < w; i++) begin
				if (!line_valid[base+i]) begin
					use_clock = use_clock + 32'd1;
					line_valid[base+i] = 1'b1;
					line_tag[base+i] = tag;
					line_stamp[base+i] = use_clock;
					miss_count = sat_inc(miss_count);
					return OUT_FILL;
				end
			end
			// all ways full: oldest stamp goes, lowest way on a tie
			victim = 0;
			for (i = 1; i < w; i++)
				if (line_stamp[base+i] < line_stamp[base+victim])
					victim = i;
			use_clock = use_clock + 32'd1;
			line_tag[base+victim] = tag;
			line_stamp[base+victim] = use_clock;
			miss_count = sat_inc(miss_count);
			evict_count = sat_inc(evict_count);
			return OUT_EVICT;
		endfunction

		function void push_result(outcome_t o, bit last_flag);
			access_result_t r;
			r.outcome = o;
			r.last = last_flag;
			r.hits = hit_count;
			r.misses = miss_count;
			r.evicts = evict_count;
			pending_results.push_back(r);
		endfunction

		function void note_access(logic [1:0] op, logic [63:0] addr);
			outcome_t res;
			res = access_line(addr);
			push_result(res, op != OP_MODIFY);
			// modify = second access to the same line, always a hit
			if (op == OP_MODIFY) begin
				res = access_line(addr);
				push_result(res, 1'b1);
			end
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_result(logic [1:0] o, logic l, logic [31:0] h, logic [31:0] m,
				logic [31:0] e);
			access_result_t x;
			if (pending_results.size() == 0) begin
				flag_mismatch("result word with nothing expected");
			end else begin
				x = pending_results.pop_front();
				if (o !== x.outcome)
					flag_mismatch($sformatf("outcome got %0d want %s", o, x.outcome.name()));
				if (l !== x.last)
					flag_mismatch($sformatf("last got %0d want %0d", l, x.last));
				if (h !== x.hits)
					flag_mismatch($sformatf("hits_total got %0d want %0d", h, x.hits));
				if (m !== x.misses)
					flag_mismatch($sformatf("misses_total got %0d want %0d", m, x.misses));
				if (e !== x.evicts)
					flag_mismatch($sformatf("evictions_total got %0d want %0d", e, x.evicts));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [ADDR_W-1:0]  address;
	logic               done;
	logic [1:0]         outcome;
	logic               last;
	logic [COUNT_W-1:0] hits_total;
	logic [COUNT_W-1:0] misses_total;
	logic [COUNT_W-1:0] evictions_total;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	lru_tag_tracker cache_mirror = new();
	int unsigned cycle_count;

	set_assoc_lru_cache_model dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.address(address),
		.done(done),
		.outcome(outcome),
		.last(last),
		.hits_total(hits_total),
		.misses_total(misses_total),
		.evictions_total(evictions_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// results are checked before a same-edge access is noted
	always @(posedge clk) begin
		if (arst_n && done)
			cache_mirror.check_result(outcome, last, hits_total, misses_total, evictions_total);
		if (arst_n && start && !busy)
			cache_mirror.note_access(operation, address);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("set_assoc_lru_cache_model verification failed");
			$finish;
		end
	end

	task automatic send_access(input logic [1:0] op, input logic [63:0] addr);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		address <= addr;
		do @(posedge clk); while (busy);
	endtask

	task automatic issue(input logic [1:0] op, input logic [63:0] addr, input bit may_idle);
		int n;
		if (may_idle && $urandom_range(0, 99) < 32) begin
			n = $urandom_range(1, 5);
			repeat (n) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		send_access(op, addr);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (cache_mirror.pending_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cache_mirror.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_geometry(input int s, input int b, input int w);
		wait_idle();
		apb_write(REG_SET_BITS, s);
		apb_write(REG_BLOCK_BITS, b);
		apb_write(REG_WAYS, w);
	endtask

	// mostly addresses built from a small tag pool so sets fill, hit and evict
	function automatic logic [63:0] make_address();
		int unsigned s, b, sb, pick;
		logic [63:0] tag, set_idx, offset, wide;
		s = cache_mirror.eff_set_bits();
		b = 32'(cache_mirror.block_bits);
		sb = s + b;
		wide = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return wide;
		tag = (pick < 17) ? {$urandom, $urandom} : 64'($urandom_range(0, cache_mirror.eff_ways() + 1));
		set_idx = 64'($urandom_range(0, (1 << s) - 1));
		offset = wide & ((64'd1 << b) - 64'd1);
		return ((sb >= 64) ? 64'd0 : (tag << sb)) | (set_idx << b) | offset;
	endfunction

	task automatic random_phase(input int n, input bit may_idle, input int pause_at);
		int i;
		for (i = 0; i < n; i++) begin
			if (i == pause_at)
				wait_idle();
			issue(2'($urandom_range(0, 3)), make_address(), may_idle);
		end
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOAD;
		address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// reset geometry: one set, one way, byte blocks
		issue(OP_LOAD, 64'd0, 1);
		issue(OP_LOAD, 64'd0, 1);
		issue(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1);
		issue(OP_MODIFY, 64'd0, 1);
		issue(OP_SPARE, 64'd0, 1);

		// 4 sets, 16-byte blocks, 2 ways: fill, refresh, LRU victim
		set_geometry(2, 4, 2);
		issue(OP_LOAD, 64'h000, 1);
		issue(OP_STORE, 64'h040, 1);
		issue(OP_LOAD, 64'h000, 1);
		issue(OP_LOAD, 64'h080, 1);
		issue(OP_MODIFY, 64'h040, 1);
		issue(OP_LOAD, 64'h010, 1);
		issue(OP_LOAD, 64'h030, 1);

		// out-of-range set bits and ways, tag squeezed out of the address
		set_geometry(7, 63, 15);
		issue(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1);
		issue(OP_LOAD, 64'd0, 1);
		issue(OP_MODIFY, 64'h8000_0000_0000_0000, 1);
		issue(OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 1);

		// ways of zero acts as direct mapped
		set_geometry(6, 32, 0);
		issue(OP_LOAD, 64'd0, 1);
		issue(OP_LOAD, 64'h0000_0001_0000_0000, 1);
		issue(OP_LOAD, 64'h0000_0040_0000_0000, 1);
		issue(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1);

		set_geometry(3, 2, 4);
		random_phase(170, 1, -1);
		set_geometry(1, 5, 8);
		random_phase(170, 1, 85);
		for (p = 0; p < 4; p++) begin
			set_geometry($urandom_range(0, 7),
				($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 63),
				$urandom_range(0, 15));
			// one phase runs back to back with no gaps
			random_phase(170, p != 0, -1);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (cache_mirror.mismatches == 0)
			$display("set_assoc_lru_cache_model verification clean");
		else
			$display("set_assoc_lru_cache_model verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/slc_pkg.sv
design/slc_cfg.sv
design/slc_lookup.sv
design/set_assoc_lru_cache_model.sv
design/slc_checker.sv
dv/tb.sv
